FILE: design/rpg_pkg.sv
// Package for the resource pressure governor: payload structs, register
// indexes, reset values and the low-threshold helpers.
// No dependencies.
`default_nettype none

package rpg_pkg;

  localparam int BYTES_W = 40;
  localparam int COUNT_W = 32;
  localparam int RUN_W = 16;
  localparam int LEVEL_W = 2;
  localparam int FLAG_W = 7;
  localparam int RATIO_W = 17;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W = 40;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 2'd0;
  localparam logic [RUN_W-1:0] RUN_SAT = 16'hFFFF;

  localparam int FLAG_ASSET = 0;
  localparam int FLAG_ACTOR = 1;
  localparam int FLAG_UPLOAD = 2;
  localparam int FLAG_GPU = 3;
  localparam int FLAG_DESC = 4;
  localparam int FLAG_NATIVE = 5;
  localparam int FLAG_TRANSIENT = 6;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ASSET_HIGH = 4'd0,
    REG_ACTOR_LIMIT = 4'd1,
    REG_UPLOAD_BYTES = 4'd2,
    REG_UPLOAD_TASKS = 4'd3,
    REG_GPU_BYTES = 4'd4,
    REG_DESC_LIMIT = 4'd5,
    REG_NATIVE_LIMIT = 4'd6,
    REG_FRAME_THR = 4'd7
  } reg_index_t;

  localparam logic [BYTES_W-1:0] ASSET_HIGH_RST = 40'd268435456;
  localparam logic [COUNT_W-1:0] ACTOR_LIMIT_RST = 32'd4096;
  localparam logic [BYTES_W-1:0] UPLOAD_BYTES_RST = 40'd67108864;
  localparam logic [COUNT_W-1:0] UPLOAD_TASKS_RST = 32'd256;
  localparam logic [BYTES_W-1:0] GPU_BYTES_RST = 40'd1073741824;
  localparam logic [COUNT_W-1:0] DESC_LIMIT_RST = 32'd65536;
  localparam logic [COUNT_W-1:0] NATIVE_LIMIT_RST = 32'd65536;
  localparam logic [COUNT_W-1:0] FRAME_THR_RST = 32'd3932190;

  typedef struct packed {
    logic [BYTES_W-1:0] asset_bytes;
    logic               asset_target_met;
    logic [COUNT_W-1:0] live_actor_count;
    logic [BYTES_W-1:0] pending_upload_bytes;
    logic [COUNT_W-1:0] pending_upload_tasks;
    logic [BYTES_W-1:0] gpu_live_bytes;
    logic [COUNT_W-1:0] live_descriptor_count;
    logic [COUNT_W-1:0] live_native_slots;
    logic               transient_over;
  } in_t;

  typedef struct packed {
    logic [FLAG_W-1:0]  pressure_mask;
    logic               asset_evict_blocked;
    logic [LEVEL_W-1:0] quality_level;
    logic [COUNT_W-1:0] quality_change_count;
    logic [COUNT_W-1:0] pressured_frame_count;
    logic [COUNT_W-1:0] violation_change_count;
    logic [COUNT_W-1:0] frame_number;
  } out_t;

  // floor(limit * ratio / 65536); ratio <= 65536 keeps the result within the limit
  function automatic logic [BYTES_W-1:0] low40(input logic [BYTES_W-1:0] limit,
                                               input logic [RATIO_W-1:0] ratio);
    logic [BYTES_W+RATIO_W-1:0] prod;
    prod = {{RATIO_W{1'b0}}, limit} * {{BYTES_W{1'b0}}, ratio};
    return prod[BYTES_W+15:16];
  endfunction

  function automatic logic [COUNT_W-1:0] low32(input logic [COUNT_W-1:0] limit,
                                               input logic [RATIO_W-1:0] ratio);
    logic [COUNT_W+RATIO_W-1:0] prod;
    prod = {{RATIO_W{1'b0}}, limit} * {{COUNT_W{1'b0}}, ratio};
    return prod[COUNT_W+15:16];
  endfunction

endpackage

`default_nettype wire

FILE: design/resource_pressure_governor.sv
// Resource pressure governor: hysteresis pressure flags, quality stepping
// and frame statistics. Depends on rpg_pkg.
//
// Usage: one frame sample per in_data transaction (valid/ready). Each sample
// yields exactly one out_data transaction carrying the pressure mask, the
// quality level and the running counters after that frame.
// Configuration: cfg_valid/cfg_index/cfg_data write one limit register per
// transaction; cfg_ready is always high and indexes above 7 are dropped.
// Low thresholds are computed when the limit is written, by a constant
// multiply on cfg_data, so a sample may follow a write in the next cycle.
// Path: an accepted sample is captured in the input register, and its result
// is registered in the output register once that register can advance.
// Throughput: one sample per cycle while the output is not stalled, set by the single
// pass from the input register to the output register.
// Stall: while a result waits in out_data with out_ready low the output register holds;
// the input register still takes one more sample if empty, then in_ready drops.
// Reset (rst, synchronous): flags, run counters, level and statistics clear,
// limits return to their defaults, both registers empty.
`default_nettype none

module resource_pressure_governor
  import rpg_pkg::*;
#(
  parameter int unsigned ASSET_LOW_RATIO = 52429,
  parameter int unsigned ACTOR_LOW_RATIO = 58982,
  parameter int unsigned UPLOAD_LOW_RATIO = 52429,
  parameter int unsigned GPU_LOW_RATIO = 52429,
  parameter int unsigned DESC_LOW_RATIO = 58982
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_t                    in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_t                        out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [RATIO_W-1:0] R_ASSET = RATIO_W'(ASSET_LOW_RATIO);
  localparam logic [RATIO_W-1:0] R_ACTOR = RATIO_W'(ACTOR_LOW_RATIO);
  localparam logic [RATIO_W-1:0] R_UPLOAD = RATIO_W'(UPLOAD_LOW_RATIO);
  localparam logic [RATIO_W-1:0] R_GPU = RATIO_W'(GPU_LOW_RATIO);
  localparam logic [RATIO_W-1:0] R_DESC = RATIO_W'(DESC_LOW_RATIO);

  logic [BYTES_W-1:0] asset_high, asset_low;
  logic [COUNT_W-1:0] actor_limit, actor_low;
  logic [BYTES_W-1:0] upload_bytes_limit, upload_bytes_low;
  logic [COUNT_W-1:0] upload_task_limit, upload_task_low;
  logic [BYTES_W-1:0] gpu_bytes_limit, gpu_bytes_low;
  logic [COUNT_W-1:0] desc_limit, desc_low;
  logic [COUNT_W-1:0] native_limit, native_low;
  logic [COUNT_W-1:0] frame_thr;

  logic [FLAG_W-1:0]  flags;
  logic [RUN_W-1:0]   pressure_run, healthy_run;
  logic [LEVEL_W-1:0] level;
  logic [COUNT_W-1:0] level_changes, pressured_frames, violation_changes, frame_total;

  logic               s1_valid;
  in_t                s1_data;
  logic               advance;

  logic [FLAG_W-1:0]  flags_next;
  logic [RUN_W-1:0]   pressure_run_next, healthy_run_next;
  logic [LEVEL_W-1:0] level_next;
  logic [COUNT_W-1:0] level_changes_next, pressured_frames_next;
  logic [COUNT_W-1:0] violation_changes_next, frame_total_next;
  logic               gpu_pressure, any_next, any_prev;
  logic [RUN_W-1:0]   run_p, run_h, deg_thr, res_thr;
  out_t               result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      asset_high <= ASSET_HIGH_RST;
      asset_low <= low40(ASSET_HIGH_RST, R_ASSET);
      actor_limit <= ACTOR_LIMIT_RST;
      actor_low <= low32(ACTOR_LIMIT_RST, R_ACTOR);
      upload_bytes_limit <= UPLOAD_BYTES_RST;
      upload_bytes_low <= low40(UPLOAD_BYTES_RST, R_UPLOAD);
      upload_task_limit <= UPLOAD_TASKS_RST;
      upload_task_low <= low32(UPLOAD_TASKS_RST, R_UPLOAD);
      gpu_bytes_limit <= GPU_BYTES_RST;
      gpu_bytes_low <= low40(GPU_BYTES_RST, R_GPU);
      desc_limit <= DESC_LIMIT_RST;
      desc_low <= low32(DESC_LIMIT_RST, R_DESC);
      native_limit <= NATIVE_LIMIT_RST;
      native_low <= low32(NATIVE_LIMIT_RST, R_DESC);
      frame_thr <= FRAME_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ASSET_HIGH: begin
          asset_high <= cfg_data;
          asset_low <= low40(cfg_data, R_ASSET);
        end
        REG_ACTOR_LIMIT: begin
          actor_limit <= cfg_data[COUNT_W-1:0];
          actor_low <= low32(cfg_data[COUNT_W-1:0], R_ACTOR);
        end
        REG_UPLOAD_BYTES: begin
          upload_bytes_limit <= cfg_data;
          upload_bytes_low <= low40(cfg_data, R_UPLOAD);
        end
        REG_UPLOAD_TASKS: begin
          upload_task_limit <= cfg_data[COUNT_W-1:0];
          upload_task_low <= low32(cfg_data[COUNT_W-1:0], R_UPLOAD);
        end
        REG_GPU_BYTES: begin
          gpu_bytes_limit <= cfg_data;
          gpu_bytes_low <= low40(cfg_data, R_GPU);
        end
        REG_DESC_LIMIT: begin
          desc_limit <= cfg_data[COUNT_W-1:0];
          desc_low <= low32(cfg_data[COUNT_W-1:0], R_DESC);
        end
        REG_NATIVE_LIMIT: begin
          native_limit <= cfg_data[COUNT_W-1:0];
          native_low <= low32(cfg_data[COUNT_W-1:0], R_DESC);
        end
        REG_FRAME_THR: begin
          frame_thr <= cfg_data[COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign advance = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  always_comb begin
    flags_next = '0;
    flags_next[FLAG_ASSET] = flags[FLAG_ASSET] ? (s1_data.asset_bytes > asset_low)
                                               : (s1_data.asset_bytes > asset_high);
    flags_next[FLAG_ACTOR] = flags[FLAG_ACTOR] ? (s1_data.live_actor_count > actor_low)
                                               : (s1_data.live_actor_count > actor_limit);
    flags_next[FLAG_UPLOAD] = flags[FLAG_UPLOAD] ?
        ((s1_data.pending_upload_bytes > upload_bytes_low) ||
         (s1_data.pending_upload_tasks > upload_task_low)) :
        ((s1_data.pending_upload_bytes > upload_bytes_limit) ||
         (s1_data.pending_upload_tasks > upload_task_limit));
    flags_next[FLAG_GPU] = flags[FLAG_GPU] ? (s1_data.gpu_live_bytes > gpu_bytes_low)
                                           : (s1_data.gpu_live_bytes > gpu_bytes_limit);
    flags_next[FLAG_DESC] = flags[FLAG_DESC] ?
        (s1_data.live_descriptor_count > desc_low) :
        (s1_data.live_descriptor_count > desc_limit);
    flags_next[FLAG_NATIVE] = flags[FLAG_NATIVE] ?
        (s1_data.live_native_slots > native_low) :
        (s1_data.live_native_slots > native_limit);
    flags_next[FLAG_TRANSIENT] = s1_data.transient_over;

    gpu_pressure = |flags_next[FLAG_TRANSIENT:FLAG_GPU];
    any_next = |flags_next;
    any_prev = |flags;
    deg_thr = frame_thr[RUN_W-1:0];
    res_thr = frame_thr[COUNT_W-1:RUN_W];

    if (gpu_pressure) begin
      run_p = (pressure_run == RUN_SAT) ? pressure_run : pressure_run + 16'd1;
      run_h = '0;
    end else begin
      run_p = '0;
      run_h = (healthy_run == RUN_SAT) ? healthy_run : healthy_run + 16'd1;
    end

    pressure_run_next = run_p;
    healthy_run_next = run_h;
    level_next = level;
    level_changes_next = level_changes;
    if (run_p >= deg_thr && level < LEVEL_MAX) begin
      level_next = level + 2'd1;
      pressure_run_next = '0;
      level_changes_next = level_changes + 32'd1;
    end else if (run_h >= res_thr && level > LEVEL_MIN) begin
      level_next = level - 2'd1;
      healthy_run_next = '0;
      level_changes_next = level_changes + 32'd1;
    end

    pressured_frames_next = any_next ? pressured_frames + 32'd1 : pressured_frames;
    violation_changes_next = (any_next != any_prev) ? violation_changes + 32'd1
                                                    : violation_changes;
    frame_total_next = frame_total + 32'd1;

    result.pressure_mask = flags_next;
    result.asset_evict_blocked = flags_next[FLAG_ASSET] && !s1_data.asset_target_met;
    result.quality_level = level_next;
    result.quality_change_count = level_changes_next;
    result.pressured_frame_count = pressured_frames_next;
    result.violation_change_count = violation_changes_next;
    result.frame_number = frame_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      pressure_run <= '0;
      healthy_run <= '0;
      level <= LEVEL_MIN;
      level_changes <= '0;
      pressured_frames <= '0;
      violation_changes <= '0;
      frame_total <= '0;
      out_valid <= 1'b0;
    end else if (s1_valid && advance) begin
      flags <= flags_next;
      pressure_run <= pressure_run_next;
      healthy_run <= healthy_run_next;
      level <= level_next;
      level_changes <= level_changes_next;
      pressured_frames <= pressured_frames_next;
      violation_changes <= violation_changes_next;
      frame_total <= frame_total_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_MAX)
    else $error("quality level out of range");

  a_runs_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(pressure_run != '0 && healthy_run != '0))
    else $error("pressure and healthy runs both nonzero");

  a_level_counted: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance && level_next != level
    |=> level_changes == $past(level_changes) + 32'd1)
    else $error("level change not counted");

  a_frame_step: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> out_valid && frame_total == $past(frame_total) + 32'd1)
    else $error("frame counter did not advance with result");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && advance) |=> frame_total == $past(frame_total) && level == $past(level))
    else $error("state changed without a transaction");
`endif

endmodule

`default_nettype wire
